/* rtl/laser_scan_polar_to_cartesian_core_defines.svh */
// Assertion macros shared by the checker of the laser scan converter.
// No dependencies; included by files that hold concurrent assertions.
`ifndef LASER_SCAN_POLAR_TO_CARTESIAN_CORE_DEFINES_SVH
`define LASER_SCAN_POLAR_TO_CARTESIAN_CORE_DEFINES_SVH

// Plain property check on the rising clock, muted while reset is asserted.
`define LSPC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication built on the plain check.
`define LSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	`LSPC_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

/* rtl/lspc_pkg.sv */
// Shared types, constants and the sine table generator of the laser scan converter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lspc_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_START_ANGLE = 2'd0;
	localparam logic [1:0] REG_ANGLE_STEP  = 2'd1;
	localparam logic [1:0] REG_MIN_RANGE   = 2'd2;
	localparam logic [1:0] REG_CUTOFF      = 2'd3;

	localparam int CFG_AW = 2;
	localparam int CFG_DW = 16;

	// Register reset values.
	localparam logic [15:0] START_ANGLE_RST = 16'h8000;
	localparam logic [15:0] ANGLE_STEP_RST  = 16'd182;
	localparam logic [15:0] MIN_RANGE_RST   = 16'd100;
	localparam logic [15:0] CUTOFF_RST      = 16'd30000;

	// Result coordinates are 21-bit signed; out-of-gate beams carry this value.
	localparam int          COORD_W     = 21;
	localparam logic [20:0] SENTINEL_MM = 21'd1000000;

	// Stream widths.
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 48;

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// One classified beam as it travels from front to back.
	typedef struct packed {
		logic [15:0] angle;
		logic [15:0] range_mm;
		logic        in_range;
		logic        last_beam;
	} beam_t;

	// Quarter-wave sine entry k in Q15 for a table of 2^bits steps per quarter turn.
	// Taylor series in Q30 up to the x^17 term, evaluated at elaboration only.
	function automatic logic [15:0] sine_q15(input int unsigned k, input int unsigned bits);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        t;
		logic signed [63:0] sum;
		logic [63:0]        r;
		x   = (HALF_PI_Q30 * 64'(k) + (64'd1 << (bits - 1))) >> bits;
		x2  = (x * x + (64'd1 << 29)) >> 30;
		t   = x;
		sum = signed'(x);
		for (int n = 1; n <= 8; n++) begin
			t = (t * x2 + (64'd1 << 29)) >> 30;
			case (n)
				1: t = t / 64'd6;
				2: t = t / 64'd20;
				3: t = t / 64'd42;
				4: t = t / 64'd72;
				5: t = t / 64'd110;
				6: t = t / 64'd156;
				7: t = t / 64'd210;
				default: t = t / 64'd272;
			endcase
			if (n % 2 == 1) begin
				sum = sum - signed'(t);
			end else begin
				sum = sum + signed'(t);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		r = (unsigned'(sum) + 64'd16384) >> 15;
		if (r > 64'd32768) begin
			r = 64'd32768;
		end
		return r[15:0];
	endfunction

endpackage

/* rtl/lspc_front.sv */
// Front of the laser scan converter: configuration registers, range gate and beam angle.
// Depends on lspc_pkg.
`timescale 1ns / 1ps

module lspc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lspc_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [lspc_pkg::CFG_DW-1:0] cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_range,
	input  logic                        s_last,
	output logic                        push_valid,
	input  logic                        push_ready,
	output lspc_pkg::beam_t             push_beam
);

	logic [15:0] start_angle_q;
	logic [15:0] angle_step_q;
	logic [15:0] min_range_q;
	logic [15:0] cutoff_q;
	logic [15:0] beam_angle_q;
	logic        at_start_q;
	logic [15:0] angle_cur;
	logic        gate_ok;
	logic        accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q <= lspc_pkg::START_ANGLE_RST;
			angle_step_q  <= lspc_pkg::ANGLE_STEP_RST;
			min_range_q   <= lspc_pkg::MIN_RANGE_RST;
			cutoff_q      <= lspc_pkg::CUTOFF_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				lspc_pkg::REG_START_ANGLE: start_angle_q <= cfg_data;
				lspc_pkg::REG_ANGLE_STEP:  angle_step_q  <= cfg_data;
				lspc_pkg::REG_MIN_RANGE:   min_range_q   <= cfg_data;
				lspc_pkg::REG_CUTOFF:      cutoff_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// The first beam of a scan uses the start angle as it stands at that moment.
	assign angle_cur = at_start_q ? start_angle_q : beam_angle_q;
	assign gate_ok   = (s_range >= min_range_q) && (s_range < cutoff_q);

	assign push_valid = s_tvalid;
	assign s_tready   = push_ready;
	assign accept     = s_tvalid && push_ready;

	always_comb begin
		push_beam.angle     = angle_cur;
		push_beam.range_mm  = s_range;
		push_beam.in_range  = gate_ok;
		push_beam.last_beam = s_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q   <= 1'b1;
			beam_angle_q <= '0;
		end else if (accept) begin
			if (s_last) begin
				at_start_q   <= 1'b1;
				beam_angle_q <= start_angle_q;
			end else begin
				at_start_q   <= 1'b0;
				beam_angle_q <= angle_cur + angle_step_q;
			end
		end
	end

endmodule

/* rtl/lspc_fifo.sv */
// Short beam queue that decouples the front of the laser scan converter from its back.
// Depends on lspc_pkg.
`timescale 1ns / 1ps

module lspc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  lspc_pkg::beam_t push_beam,
	output logic            pop_valid,
	input  logic            pop_ready,
	output lspc_pkg::beam_t pop_beam
);

	lspc_pkg::beam_t                 slot_q [lspc_pkg::QUEUE_DEPTH];
	logic [lspc_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [lspc_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [lspc_pkg::QUEUE_AW:0]     count_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = (count_q != (lspc_pkg::QUEUE_AW + 1)'(lspc_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_beam   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_beam;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/lspc_back.sv */
// Back of the laser scan converter: sine table lookup, scaling and rounding to millimetres.
// Depends on lspc_pkg; holds the quarter-wave sine table built by lspc_pkg::sine_q15.
`timescale 1ns / 1ps

module lspc_back #(
	parameter int SINE_TABLE_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pop_valid,
	output logic                         pop_ready,
	input  lspc_pkg::beam_t              pop_beam,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [lspc_pkg::COORD_W-1:0] x_mm,
	output logic [lspc_pkg::COORD_W-1:0] y_mm,
	output logic                         in_range,
	output logic                         scan_end
);

	localparam int QSTEPS = 1 << SINE_TABLE_BITS;
	localparam int AW     = SINE_TABLE_BITS + 1;

	logic [15:0] sine_rom [QSTEPS + 1];

	for (genvar k = 0; k <= QSTEPS; k++) begin : g_rom
		assign sine_rom[k] = lspc_pkg::sine_q15(k, SINE_TABLE_BITS);
	end

	logic                       adv;
	logic [1:0]                 quad_sin;
	logic [1:0]                 quad_cos;
	logic [SINE_TABLE_BITS-1:0] idx;
	logic [AW-1:0]              addr_sin;
	logic [AW-1:0]              addr_cos;

	logic        v_s1, v_s2, v_s3;
	logic [15:0] sin_mag_s1, cos_mag_s1, range_s1;
	logic        sin_neg_s1, cos_neg_s1, ok_s1, last_s1;
	logic [31:0] prod_x_s2, prod_y_s2;
	logic        neg_x_s2, neg_y_s2, ok_s2, last_s2;
	logic [lspc_pkg::COORD_W-1:0] x_s3, y_s3;
	logic        ok_s3, last_s3;
	logic [31:0] round_x, round_y;
	logic [lspc_pkg::COORD_W-1:0] mag_x, mag_y;

	// The whole back moves as one while the output register is free or being taken.
	assign adv       = !v_s3 || m_tready;
	assign pop_ready = adv;

	// Cosine reads the sine of the angle a quarter turn further on.
	assign quad_sin = pop_beam.angle[15:14];
	assign quad_cos = quad_sin + 2'd1;
	assign idx      = pop_beam.angle[13 -: SINE_TABLE_BITS];
	assign addr_sin = quad_sin[0] ? (AW'(QSTEPS) - AW'(idx)) : AW'(idx);
	assign addr_cos = quad_cos[0] ? (AW'(QSTEPS) - AW'(idx)) : AW'(idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sin_mag_s1 <= sine_rom[addr_sin];
			cos_mag_s1 <= sine_rom[addr_cos];
			sin_neg_s1 <= quad_sin[1];
			cos_neg_s1 <= quad_cos[1];
			range_s1   <= pop_beam.range_mm;
			ok_s1      <= pop_beam.in_range;
			last_s1    <= pop_beam.last_beam;

			prod_x_s2 <= range_s1 * cos_mag_s1;
			prod_y_s2 <= range_s1 * sin_mag_s1;
			neg_x_s2  <= cos_neg_s1;
			neg_y_s2  <= sin_neg_s1;
			ok_s2     <= ok_s1;
			last_s2   <= last_s1;

			x_s3    <= ok_s2 ? (neg_x_s2 ? -mag_x : mag_x) : lspc_pkg::SENTINEL_MM;
			y_s3    <= ok_s2 ? (neg_y_s2 ? -mag_y : mag_y) : lspc_pkg::SENTINEL_MM;
			ok_s3   <= ok_s2;
			last_s3 <= last_s2;
		end
	end

	// Round half up on the magnitude, so ties go away from zero after the sign is applied.
	assign round_x = prod_x_s2 + 32'd16384;
	assign round_y = prod_y_s2 + 32'd16384;
	assign mag_x   = lspc_pkg::COORD_W'(round_x[31:15]);
	assign mag_y   = lspc_pkg::COORD_W'(round_y[31:15]);

	assign m_tvalid = v_s3;
	assign x_mm     = x_s3;
	assign y_mm     = y_s3;
	assign in_range = ok_s3;
	assign scan_end = last_s3;

endmodule

/* rtl/laser_scan_polar_to_cartesian_core.sv */
// Laser scan polar-to-Cartesian converter, top level.
// An accepted beat passes through the queue, then the back's s1, s2 and s3 registers.
// Throughput: one beat per cycle unless the output stalls; each cycle the back does a pair of
// sine table reads and a pair of 16 by 16 multiplies; the four-entry queue absorbs stalls.
// Reset (arst_n low, asynchronous): registers return to their defaults, queue and pipeline
// empty, the next beam starts a scan. The sine table is constant and needs no clearing pass.
`timescale 1ns / 1ps

// The front holds the four configuration registers, applies the range gate and keeps
// the running beam angle. Each accepted beat becomes one classified beam that waits in
// a short queue. The back pulls beams from the queue, looks up sine and cosine in the
// quarter-wave table, scales them by the range and rounds to millimetres.
module laser_scan_polar_to_cartesian_core #(
	parameter int SINE_TABLE_BITS = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write port; indexes: start angle, angle step, minimum range, cutoff.
	input  logic                             cfg_we,
	input  logic [lspc_pkg::CFG_AW-1:0]      cfg_addr,
	input  logic [lspc_pkg::CFG_DW-1:0]      cfg_data,
	// Input beats.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [lspc_pkg::IN_TDATA_W-1:0]  s_tdata,  // [15:0] range_mm
	input  logic                             s_tlast,  // last_beam
	// Result beats.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lspc_pkg::OUT_TDATA_W-1:0] m_tdata,  // [20:0] x_mm, [41:21] y_mm, zero fill
	output logic                             m_tuser,  // in_range
	output logic                             m_tlast   // scan_end
);

	logic                         push_valid;
	logic                         push_ready;
	lspc_pkg::beam_t              push_beam;
	logic                         pop_valid;
	logic                         pop_ready;
	lspc_pkg::beam_t              pop_beam;
	logic [lspc_pkg::COORD_W-1:0] x_mm;
	logic [lspc_pkg::COORD_W-1:0] y_mm;

	lspc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_range    (s_tdata[15:0]),
		.s_last     (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_beam  (push_beam)
	);

	// The queue lets the front keep taking beats while a result waits on the output.
	lspc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_beam  (push_beam),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_beam   (pop_beam)
	);

	lspc_back #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_beam  (pop_beam),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.x_mm      (x_mm),
		.y_mm      (y_mm),
		.in_range  (m_tuser),
		.scan_end  (m_tlast)
	);

	// Coordinates packed low to high, upper bits zero to fill whole bytes.
	assign m_tdata = {(lspc_pkg::OUT_TDATA_W - 2 * lspc_pkg::COORD_W)'(0), y_mm, x_mm};

endmodule

/* rtl/lspc_checker.sv */
// Port-level checker for the laser scan converter, bound to its top level.
// Depends on lspc_pkg and laser_scan_polar_to_cartesian_core_defines.svh.
`timescale 1ns / 1ps
`include "laser_scan_polar_to_cartesian_core_defines.svh"

module lspc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [lspc_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                             m_tuser,
	input logic                             m_tlast
);

	`LSPC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
	`LSPC_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result beat changed")
	`LSPC_ASSERT(a_sentinel, clk, arst_n, (m_tvalid && !m_tuser) |-> (m_tdata[20:0] == lspc_pkg::SENTINEL_MM && m_tdata[41:21] == lspc_pkg::SENTINEL_MM), "gated beam without sentinel")
	`LSPC_ASSERT(a_bound, clk, arst_n, (m_tvalid && m_tuser) |-> ((m_tdata[20:16] == 5'h00 || m_tdata[20:16] == 5'h1f) && (m_tdata[41:37] == 5'h00 || m_tdata[41:37] == 5'h1f)), "coordinate beyond range")

endmodule

bind laser_scan_polar_to_cartesian_core lspc_checker u_lspc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

/* bench/testbench.sv */
// Self-checking bench for the laser scan polar-to-Cartesian converter: drives range beats,
// predicts every x/y point and compares it. Depends on lspc_pkg and the core; reads no files.
`timescale 1ns / 1ps

module testbench;

	// Table size of the device under test; the bench builds its own table of the same size.
	localparam int TRIG_BITS   = 12;
	localparam int QUARTER     = 1 << TRIG_BITS;
	localparam int IDLE_PCT    = 23;
	localparam int STUCK_LIMIT = 2000;
	localparam int REPORT_MAX  = 10;

	typedef longint unsigned u64_t;

	// One expected result beat, field by field.
	typedef struct packed {
		logic [lspc_pkg::COORD_W-1:0] x_mm;
		logic [lspc_pkg::COORD_W-1:0] y_mm;
		logic                         in_range;
		logic                         scan_end;
	} point_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [lspc_pkg::CFG_AW-1:0]      cfg_addr;
	logic [lspc_pkg::CFG_DW-1:0]      cfg_data;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [lspc_pkg::IN_TDATA_W-1:0]  s_tdata;   // [15:0] range_mm
	logic                             s_tlast;   // last_beam
	logic                             m_tvalid;
	logic                             m_tready;
	logic [lspc_pkg::OUT_TDATA_W-1:0] m_tdata;   // [20:0] x_mm, [41:21] y_mm, zero fill
	logic                             m_tuser;   // in_range
	logic                             m_tlast;   // scan_end

	// Quarter-wave sine table in Q15 (32768 = 1.0), entries 0 through QUARTER.
	int trig_table [0:QUARTER];

	// The bench's own copy of the register file and of the beam angle state.
	logic [15:0] start_ang_cfg;
	logic [15:0] step_cfg;
	logic [15:0] min_cfg;
	logic [15:0] cut_cfg;
	logic [15:0] beam_ang;
	logic        first_beam;

	point_t expected_points [$];

	int mismatches;
	int beams_sent;
	int points_checked;
	int gated_out;
	int scans_closed;
	int cfg_writes;

	// Idle controls. hold_request is set by a test right after an accepted input beat
	// and picked up by the result sink at the next falling edge.
	bit send_gaps;
	bit recv_gaps;
	int hold_request;

	laser_scan_polar_to_cartesian_core #(
		.SINE_TABLE_BITS(TRIG_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Each entry is a Taylor series of sin evaluated in Q30 up to the x^17 term,
	// with every term rounded and then divided, and the sum rounded to nearest in Q15.
	function automatic void build_trig_table();
		u64_t   ang;
		u64_t   ang2;
		u64_t   term;
		u64_t   rounded;
		longint acc;
		for (int k = 0; k <= QUARTER; k++) begin
			ang  = (u64_t'(1686629713) * u64_t'(k) + u64_t'(QUARTER / 2)) / u64_t'(QUARTER);
			ang2 = (ang * ang + (u64_t'(1) << 29)) >> 30;
			term = ang;
			acc  = longint'(ang);
			for (int n = 1; n <= 8; n++) begin
				term = (term * ang2 + (u64_t'(1) << 29)) >> 30;
				term = term / u64_t'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			rounded = (u64_t'(acc) + 64'd16384) >> 15;
			trig_table[k] = (rounded > 64'd32768) ? 32768 : int'(rounded);
		end
	endfunction

	// Bits 15..14 pick the quadrant; the odd quadrants read the table backwards and
	// the lower half turn is negated. No interpolation between entries.
	function automatic int table_sin(input logic [15:0] ang);
		int idx;
		int v;
		idx = int'(ang >> (14 - TRIG_BITS)) & (QUARTER - 1);
		v   = ang[14] ? trig_table[QUARTER - idx] : trig_table[idx];
		return ang[15] ? -v : v;
	endfunction

	// range * trig / 32768, rounded to nearest with ties away from zero.
	function automatic logic [lspc_pkg::COORD_W-1:0] scale_mm(input logic [15:0] rng,
			input int trig);
		longint mag;
		longint prod;
		mag  = (trig < 0) ? -longint'(trig) : longint'(trig);
		prod = (longint'(rng) * mag + 16384) >>> 15;
		if (trig < 0) begin
			prod = -prod;
		end
		return prod[lspc_pkg::COORD_W-1:0];
	endfunction

	// Works out the point for one accepted beam and advances the beam angle. The
	// start angle is read when a scan begins, so a write to it lands on the next scan.
	function automatic point_t predict_point(input logic [15:0] rng, input logic last);
		point_t      pt;
		logic [15:0] ang;
		logic        gate_ok;
		ang     = first_beam ? start_ang_cfg : beam_ang;
		gate_ok = (rng >= min_cfg) && (rng < cut_cfg);
		pt.in_range = gate_ok;
		pt.scan_end = last;
		if (gate_ok) begin
			pt.x_mm = scale_mm(rng, table_sin(ang + 16'd16384));
			pt.y_mm = scale_mm(rng, table_sin(ang));
		end else begin
			pt.x_mm = 21'd1000000;
			pt.y_mm = 21'd1000000;
			gated_out++;
		end
		if (last) begin
			first_beam = 1'b1;
			beam_ang   = start_ang_cfg;
		end else begin
			first_beam = 1'b0;
			beam_ang   = ang + step_cfg;
		end
		return pt;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("ERROR at %0t ns: %s", $time, msg);
		end
	endtask

	task automatic compare_field(input string name, input logic [lspc_pkg::COORD_W-1:0] want_v,
			input logic [lspc_pkg::COORD_W-1:0] got_v);
		if (got_v !== want_v) begin
			note_failure($sformatf("%s expected %0d, got %0d (result beat %0d)", name,
				$signed(want_v), $signed(got_v), points_checked));
		end
	endtask

	// Every result beat taken by the sink is held against the oldest prediction.
	always @(posedge clk) begin : check_points
		point_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_points.size() == 0) begin
				note_failure($sformatf("result beat with nothing expected, tdata %h", m_tdata));
			end else begin
				want = expected_points.pop_front();
				compare_field("x_mm", want.x_mm, m_tdata[lspc_pkg::COORD_W-1:0]);
				compare_field("y_mm", want.y_mm,
					m_tdata[2*lspc_pkg::COORD_W-1:lspc_pkg::COORD_W]);
				compare_field("in_range", lspc_pkg::COORD_W'(want.in_range),
					lspc_pkg::COORD_W'(m_tuser));
				compare_field("scan_end", lspc_pkg::COORD_W'(want.scan_end),
					lspc_pkg::COORD_W'(m_tlast));
				compare_field("tdata fill", '0,
					lspc_pkg::COORD_W'(m_tdata[lspc_pkg::OUT_TDATA_W-1:2*lspc_pkg::COORD_W]));
				points_checked++;
			end
		end
	end

	// The run is declared hung once the idle count, cleared whenever a beat moves on either side, reaches STUCK_LIMIT.
	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stuck = 0;
			end else begin
				stuck++;
			end
		end
		$display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
			STUCK_LIMIT, expected_points.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// Result sink: random back-pressure, plus long holds on request.
	// ------------------------------------------------------------------

	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				stall_left   = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = !(recv_gaps && ($urandom_range(99) < IDLE_PCT));
			end
		end
	end

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------

	// Offers one beam from a falling edge and returns at the rising edge that takes it.
	// tvalid stays high into the next call unless that call opens a gap.
	task automatic send_beam(input logic [15:0] rng, input logic last);
		point_t pt;
		@(negedge clk);
		while (send_gaps && ($urandom_range(99) < IDLE_PCT)) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = rng;
		s_tlast  = last;
		do @(posedge clk); while (!s_tready);
		pt = predict_point(rng, last);
		expected_points.insert(expected_points.size(), pt);
		beams_sent++;
		if (last) begin
			scans_closed++;
		end
	endtask

	// Stops offering and waits until every predicted point has come back, then lets the
	// pipeline settle. Returns on a falling edge, ready for a write.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (expected_points.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	// Register write, one cycle of write enable; called on a falling edge only.
	task automatic cfg_write(input logic [lspc_pkg::CFG_AW-1:0] idx, input logic [15:0] value);
		cfg_we   = 1'b1;
		cfg_addr = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			lspc_pkg::REG_START_ANGLE: start_ang_cfg = value;
			lspc_pkg::REG_ANGLE_STEP:  step_cfg      = value;
			lspc_pkg::REG_MIN_RANGE:   min_cfg       = value;
			lspc_pkg::REG_CUTOFF:      cut_cfg       = value;
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic write_all(input logic [15:0] st, input logic [15:0] stp,
			input logic [15:0] mn, input logic [15:0] ct);
		cfg_write(lspc_pkg::REG_START_ANGLE, st);
		cfg_write(lspc_pkg::REG_ANGLE_STEP, stp);
		cfg_write(lspc_pkg::REG_MIN_RANGE, mn);
		cfg_write(lspc_pkg::REG_CUTOFF, ct);
	endtask

	// Mostly readings inside the gate, with a share right on its edges, the two ends
	// of the field, and fully random values so every range bit toggles.
	function automatic logic [15:0] pick_range();
		case ($urandom_range(15))
			0: return min_cfg - 16'd1;
			1: return min_cfg;
			2: return cut_cfg - 16'd1;
			3: return cut_cfg;
			4: return ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000;
			5: return 16'($urandom);
			default: begin
				if (min_cfg < cut_cfg) begin
					return 16'($urandom_range(int'(min_cfg), int'(cut_cfg) - 1));
				end
				return 16'($urandom);
			end
		endcase
	endfunction

	// A run of beams; close marks the final one as the end of the scan.
	task automatic send_scan(input int len, input bit close);
		for (int i = 0; i < len; i++) begin
			send_beam(pick_range(), close && (i == len - 1));
		end
	endtask

	// Random register setting, reaching the step extremes and a closed or wide gate at times.
	task automatic random_setup();
		logic [15:0] st;
		logic [15:0] stp;
		logic [15:0] mn;
		logic [15:0] ct;
		st = 16'($urandom);
		case ($urandom_range(3))
			0: stp = 16'($urandom);
			1: stp = ($urandom_range(1) == 1) ? 16'h8000 : 16'h7FFF;
			default: begin
				stp = 16'($urandom_range(1, 600));
				if ($urandom_range(1) == 1) begin
					stp = -stp;
				end
			end
		endcase
		case ($urandom_range(5))
			0: mn = 16'd0;
			1: mn = 16'($urandom);
			default: mn = 16'($urandom_range(0, 800));
		endcase
		case ($urandom_range(5))
			0: ct = 16'hFFFF;
			1: ct = 16'($urandom);
			default: ct = 16'($urandom_range(2000, 60000));
		endcase
		write_all(st, stp, mn, ct);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Register defaults straight out of reset: the gate edges at 100 and 30000 mm,
	// zero range, the no-return code, and a first scan that starts at -32768.
	task automatic test_reset_defaults();
		send_beam(16'd0, 1'b0);
		send_beam(16'd99, 1'b0);
		send_beam(16'd100, 1'b0);
		send_beam(16'd15000, 1'b0);
		send_beam(16'd29999, 1'b0);
		send_beam(16'd30000, 1'b0);
		send_beam(16'hFFFF, 1'b1);
	endtask

	// Widest gate and quarter-turn steps, so the beams land on the axes and the angle
	// wraps past a full turn; then the largest start with the most negative step.
	task automatic test_register_extremes();
		drain_results();
		write_all(16'h0000, 16'h4000, 16'd0, 16'hFFFF);
		send_beam(16'd0, 1'b0);
		send_beam(16'd65534, 1'b0);
		send_beam(16'd65534, 1'b0);
		send_beam(16'd65534, 1'b0);
		send_beam(16'd65534, 1'b1);
		drain_results();
		write_all(16'h7FFF, 16'h8000, 16'd0, 16'hFFFF);
		send_beam(16'd65534, 1'b0);
		send_beam(16'd65534, 1'b1);
	endtask

	// A minimum that is not below the cutoff rejects every reading.
	task automatic test_gate_closed();
		drain_results();
		write_all(16'd0, 16'd100, 16'd5000, 16'd5000);
		send_beam(16'd4999, 1'b0);
		send_beam(16'd5000, 1'b0);
		send_beam(16'd5001, 1'b1);
		drain_results();
		write_all(16'd0, 16'd100, 16'hFFFF, 16'd0);
		send_beam(16'd30000, 1'b1);
	endtask

	// A start angle written in the middle of a scan must only show on the next scan.
	task automatic test_start_mid_scan();
		drain_results();
		write_all(16'd0, 16'd1000, 16'd100, 16'd30000);
		send_beam(16'd1000, 1'b0);
		send_beam(16'd2000, 1'b0);
		drain_results();
		cfg_write(lspc_pkg::REG_START_ANGLE, 16'd20000);
		send_beam(16'd3000, 1'b0);
		send_beam(16'd4000, 1'b1);
		send_beam(16'd5000, 1'b1);
	endtask

	// The sink holds off for a long stretch while beams keep coming, so the queue fills
	// and the input must stall without losing or repeating anything.
	task automatic test_back_pressure();
		drain_results();
		random_setup();
		send_gaps = 1'b0;
		send_scan(8, 1'b0);
		hold_request = 100;
		send_scan(30, 1'b1);
		send_scan(30, 1'b1);
		send_gaps = 1'b1;
		drain_results();
	endtask

	// Full-rate traffic with neither side ever idle.
	task automatic test_burst_no_idle();
		int budget;
		int len;
		drain_results();
		random_setup();
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		budget    = 150;
		while (budget > 0) begin
			len = $urandom_range(1, 40);
			if (len > budget) begin
				len = budget;
			end
			send_scan(len, 1'b1);
			budget -= len;
		end
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
	endtask

	// Several register settings with random scans; a phase may end mid-scan, so
	// later writes also fall between the beams of one scan. In one phase the
	// sender stops until every result is back before carrying on.
	task automatic test_random_scans();
		int  budget;
		int  len;
		bit  close;
		bit  paused;
		paused = 1'b0;
		for (int ph = 0; ph < 7; ph++) begin
			drain_results();
			random_setup();
			budget = 175;
			while (budget > 0) begin
				len   = $urandom_range(1, 48);
				close = 1'b1;
				if (len >= budget) begin
					len   = budget;
					close = ($urandom_range(1) == 1);
				end
				send_scan(len, close);
				budget -= len;
				if (ph == 3 && !paused && budget < 100) begin
					drain_results();
					paused = 1'b1;
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_addr     = '0;
		cfg_data     = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tlast      = 1'b0;
		send_gaps    = 1'b1;
		recv_gaps    = 1'b1;
		hold_request = 0;
		mismatches     = 0;
		beams_sent     = 0;
		points_checked = 0;
		gated_out      = 0;
		scans_closed   = 0;
		cfg_writes     = 0;

		// Register values after reset, and the first beam begins a scan.
		start_ang_cfg = 16'h8000;
		step_cfg      = 16'd182;
		min_cfg       = 16'd100;
		cut_cfg       = 16'd30000;
		beam_ang      = 16'h8000;
		first_beam    = 1'b1;
		build_trig_table();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_register_extremes();
		test_gate_closed();
		test_start_mid_scan();
		test_back_pressure();
		test_burst_no_idle();
		test_random_scans();

		// Everything predicted must have come back; then watch a little longer for strays.
		drain_results();
		repeat (8) @(posedge clk);

		$display("Run covered %0d beams in %0d closed scans (%0d outside the gate),",
			beams_sent, scans_closed, gated_out);
		$display("%0d register writes; compared %0d result beats, %0d field mismatches.",
			cfg_writes, points_checked, mismatches);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
